// File: rtl/assert_macros.svh
// Assertion macros shared by the checker file of the tick scaling block.
// Depends on nothing; a file that uses them supplies clk and rst_n by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, off while the given reset is low
`define ATS_ASSERT_EDGE(label, clk_sig, rstn_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (prop)) \
        else $error(msg);

// Same, on the local clk and rst_n
`define ATS_ASSERT(label, prop, msg) \
    `ATS_ASSERT_EDGE(label, clk, rst_n, prop, msg)

`endif

// File: rtl/ats_pkg.sv
// Types and constants of the axis tick scaling block.
// Used by ats_alu and axis_tick_scale; depends on nothing.
package ats_pkg;

    localparam int ALU_W = 36;

    typedef logic signed [ALU_W-1:0] alu_word_t;

    typedef struct packed {
        logic sub;
    } alu_ctrl_t;

    typedef struct packed {
        logic neg;
        logic zero;
    } alu_flags_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ORDER,
        ST_EQUAL,
        ST_RANGE,
        ST_SEARCH,
        ST_ABS,
        ST_DIV,
        ST_FIRST,
        ST_FIX,
        ST_CMP,
        ST_ADV,
        ST_HF_ADD,
        ST_HF_CMP,
        ST_HL_SUB,
        ST_HL_CMP,
        ST_FINISH
    } state_t;

    // Powers of ten, index is the exponent
    localparam logic [33:0] POW10 [0:10] = '{
        34'd1, 34'd10, 34'd100, 34'd1000, 34'd10000, 34'd100000,
        34'd1000000, 34'd10000000, 34'd100000000, 34'd1000000000,
        34'd10000000000
    };

    localparam logic [3:0]  HALVE_LIMIT = 4'd5;   // fewer intervals than this halve
    localparam logic [30:0] STEP_EQUAL  = 31'd2;  // one integer unit in half units
    localparam logic [4:0]  DIV_LAST    = 5'd31;  // last bit of the remainder loop

endpackage

// File: rtl/ats_alu.sv
// Shared add/subtract unit with sign and zero flags.
// Depends on ats_pkg.
module ats_alu (
    input  ats_pkg::alu_word_t  opa,
    input  ats_pkg::alu_word_t  opb,
    input  ats_pkg::alu_ctrl_t  ctrl,
    output ats_pkg::alu_word_t  res,
    output ats_pkg::alu_flags_t flags
);
    import ats_pkg::*;

    // Add or subtract, then flag the result
    always_comb
    begin
        if (ctrl.sub)
        begin
            res = opa - opb;
        end
        else
        begin
            res = opa + opb;
        end
        flags.neg  = res[ALU_W-1];
        flags.zero = (res == '0);
    end

endmodule

// File: rtl/axis_tick_scale.sv
// Top level of the axis tick scaling block: sequencer, working registers, output word.
// Depends on ats_pkg and ats_alu.
//
// Takes two range ends as one word and returns one word with the ordered ends, the major
// tick step and the first and last tick in half units. All arithmetic on the values runs
// through one shared 36-bit add/subtract unit under a state machine, in these steps: order
// and size the range, the power-of-ten search, the bit-serial remainder of the low end,
// place the first tick, count the intervals (1 to 11 intervals), halve the step where
// needed, and load the output. Equal ends go from ordering through a widening step
// straight to the output load. The input is not ready while a word is in work; a finished
// word waits in the output register while the next input word is taken, and the load
// stalls only while that register is still full.
module axis_tick_scale (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // first_value [31:0], second_value [63:32]
    input  logic [63:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // range_low [32:0], range_high [64:33], tick_step [95:65],
    // first_tick [130:96], last_tick [165:131], zero pad [167:166]
    output logic [167:0] m_axis_tdata,
    // step_halved [0]
    output logic [0:0]   m_axis_tuser
);
    import ats_pkg::*;

    state_t state_reg, state_next;

    logic signed [31:0] a_reg, a_next;
    logic signed [31:0] b_reg, b_next;
    logic signed [31:0] lo_reg, lo_next;
    logic signed [31:0] hi_reg, hi_next;
    logic signed [32:0] rlo_reg, rlo_next;
    logic [31:0]        range_reg, range_next;
    logic [3:0]         exp_reg, exp_next;
    logic [31:0]        mag_reg, mag_next;
    logic [29:0]        rem_reg, rem_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic signed [32:0] first_reg, first_next;
    logic signed [32:0] last_reg, last_next;
    logic [3:0]         n_reg, n_next;
    logic signed [34:0] fh_reg, fh_next;
    logic signed [34:0] lh_reg, lh_next;
    logic signed [34:0] tmp_reg, tmp_next;
    logic [30:0]        step_reg, step_next;
    logic               halved_reg, halved_next;

    // Output word
    logic               ovalid_reg, ovalid_next;
    logic signed [32:0] o_rlo_reg;
    logic signed [31:0] o_rhi_reg;
    logic [30:0]        o_step_reg;
    logic signed [34:0] o_first_reg;
    logic signed [34:0] o_last_reg;
    logic               o_halved_reg;
    logic               out_load;

    logic [33:0]        p_w;
    logic [3:0]         exp_inc;
    logic [30:0]        div_w;
    logic signed [34:0] lo2_w;
    logic signed [34:0] hi2_w;

    alu_word_t  alu_a, alu_b, alu_res;
    alu_ctrl_t  alu_ctrl;
    alu_flags_t alu_flags;

    ats_alu u_alu (
        .opa   (alu_a),
        .opb   (alu_b),
        .ctrl  (alu_ctrl),
        .res   (alu_res),
        .flags (alu_flags)
    );

    assign exp_inc = exp_reg + 4'd1;
    assign p_w     = POW10[exp_reg];
    assign div_w   = {rem_reg, mag_reg[31]};
    assign lo2_w   = 35'($signed({lo_reg, 1'b0}));
    assign hi2_w   = 35'($signed({hi_reg, 1'b0}));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_ORDER;
                end
            end
            ST_ORDER:
            begin
                state_next = alu_flags.zero ? ST_EQUAL : ST_RANGE;
            end
            ST_EQUAL:  state_next = ST_FINISH;
            ST_RANGE:  state_next = ST_SEARCH;
            ST_SEARCH:
            begin
                if (!alu_flags.neg)
                begin
                    state_next = ST_ABS;
                end
            end
            ST_ABS:    state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                state_next = (lo_reg[31] && (rem_reg != '0)) ? ST_FIX : ST_CMP;
            end
            ST_FIX:    state_next = ST_CMP;
            ST_CMP:
            begin
                if (!alu_flags.neg)
                begin
                    state_next = (n_reg < HALVE_LIMIT) ? ST_HF_ADD : ST_FINISH;
                end
                else
                begin
                    state_next = ST_ADV;
                end
            end
            ST_ADV:    state_next = ST_CMP;
            ST_HF_ADD: state_next = ST_HF_CMP;
            ST_HF_CMP: state_next = ST_HL_SUB;
            ST_HL_SUB: state_next = ST_HL_CMP;
            ST_HL_CMP: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!ovalid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, unit operands, output load
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        out_load      = (state_reg == ST_FINISH) && (!ovalid_reg || m_axis_tready);
        alu_a         = '0;
        alu_b         = '0;
        alu_ctrl.sub  = 1'b1;
        unique case (state_reg)
            ST_ORDER:
            begin
                alu_a = alu_word_t'(a_reg);
                alu_b = alu_word_t'(b_reg);
            end
            ST_EQUAL:
            begin
                alu_a = alu_word_t'(hi_reg);
                alu_b = alu_word_t'(1);
            end
            ST_RANGE:
            begin
                alu_a = alu_word_t'(hi_reg);
                alu_b = alu_word_t'(lo_reg);
            end
            ST_SEARCH:
            begin
                alu_a = alu_word_t'(POW10[exp_inc]);
                alu_b = alu_word_t'(range_reg);
            end
            ST_ABS:
            begin
                alu_b        = alu_word_t'(lo_reg);
                alu_ctrl.sub = lo_reg[31];
            end
            ST_DIV:
            begin
                alu_a = alu_word_t'(div_w);
                alu_b = alu_word_t'(p_w);
            end
            ST_FIRST:
            begin
                alu_a        = alu_word_t'(lo_reg);
                alu_b        = alu_word_t'(rem_reg);
                alu_ctrl.sub = !lo_reg[31];
            end
            ST_FIX:
            begin
                alu_a = alu_word_t'(first_reg);
                alu_b = alu_word_t'(p_w);
            end
            ST_CMP:
            begin
                alu_a = alu_word_t'(last_reg);
                alu_b = alu_word_t'(hi_reg);
            end
            ST_ADV:
            begin
                alu_a        = alu_word_t'(last_reg);
                alu_b        = alu_word_t'(p_w);
                alu_ctrl.sub = 1'b0;
            end
            ST_HF_ADD:
            begin
                alu_a        = alu_word_t'(fh_reg);
                alu_b        = alu_word_t'(p_w);
                alu_ctrl.sub = 1'b0;
            end
            ST_HF_CMP:
            begin
                alu_a = alu_word_t'(tmp_reg);
                alu_b = alu_word_t'(lo2_w);
            end
            ST_HL_SUB:
            begin
                alu_a = alu_word_t'(lh_reg);
                alu_b = alu_word_t'(p_w);
            end
            ST_HL_CMP:
            begin
                alu_a = alu_word_t'(tmp_reg);
                alu_b = alu_word_t'(hi2_w);
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    // Working register updates
    always_comb
    begin
        a_next      = a_reg;
        b_next      = b_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        rlo_next    = rlo_reg;
        range_next  = range_reg;
        exp_next    = exp_reg;
        mag_next    = mag_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        first_next  = first_reg;
        last_next   = last_reg;
        n_next      = n_reg;
        fh_next     = fh_reg;
        lh_next     = lh_reg;
        tmp_next    = tmp_reg;
        step_next   = step_reg;
        halved_next = halved_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                a_next = s_axis_tdata[31:0];
                b_next = s_axis_tdata[63:32];
            end
            ST_ORDER:
            begin
                // order the ends on the sign of a - b
                lo_next = alu_flags.neg ? a_reg : b_reg;
                hi_next = alu_flags.neg ? b_reg : a_reg;
            end
            ST_EQUAL:
            begin
                rlo_next    = alu_res[32:0];
                fh_next     = 35'($signed({alu_res[32:0], 1'b0}));
                lh_next     = hi2_w;
                step_next   = STEP_EQUAL;
                halved_next = 1'b0;
            end
            ST_RANGE:
            begin
                rlo_next   = 33'(lo_reg);
                range_next = alu_res[31:0];
                exp_next   = '0;
            end
            ST_SEARCH:
            begin
                // advance while ten steps still fall short of the range
                if (alu_flags.neg)
                begin
                    exp_next = exp_inc;
                end
            end
            ST_ABS:
            begin
                mag_next = alu_res[31:0];
                rem_next = '0;
                cnt_next = '0;
            end
            ST_DIV:
            begin
                // one restoring step of |lo| mod step
                rem_next = alu_flags.neg ? div_w[29:0] : alu_res[29:0];
                mag_next = {mag_reg[30:0], 1'b0};
                cnt_next = cnt_reg + 5'd1;
            end
            ST_FIRST:
            begin
                first_next = alu_res[32:0];
                last_next  = alu_res[32:0];
                n_next     = '0;
            end
            ST_FIX:
            begin
                first_next = alu_res[32:0];
                last_next  = alu_res[32:0];
            end
            ST_CMP:
            begin
                fh_next = 35'($signed({first_reg, 1'b0}));
                lh_next = 35'($signed({last_reg, 1'b0}));
                if (!alu_flags.neg)
                begin
                    if (n_reg < HALVE_LIMIT)
                    begin
                        halved_next = 1'b1;
                        step_next   = 31'(p_w);
                    end
                    else
                    begin
                        halved_next = 1'b0;
                        step_next   = 31'({p_w, 1'b0});
                    end
                end
            end
            ST_ADV:
            begin
                last_next = alu_res[32:0];
                n_next    = n_reg + 4'd1;
            end
            ST_HF_ADD,
            ST_HL_SUB:
            begin
                tmp_next = alu_res[34:0];
            end
            ST_HF_CMP:
            begin
                // pull the first tick in where it still covers the low end
                if (alu_flags.neg || alu_flags.zero)
                begin
                    fh_next = tmp_reg;
                end
            end
            ST_HL_CMP:
            begin
                // pull the last tick in where it still covers the high end
                if (!alu_flags.neg)
                begin
                    lh_next = tmp_reg;
                end
            end
            default:
            begin
                tmp_next = tmp_reg;
            end
        endcase
    end

    // Output valid
    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (out_load)
        begin
            ovalid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        rlo_reg    <= rlo_next;
        range_reg  <= range_next;
        exp_reg    <= exp_next;
        mag_reg    <= mag_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        first_reg  <= first_next;
        last_reg   <= last_next;
        n_reg      <= n_next;
        fh_reg     <= fh_next;
        lh_reg     <= lh_next;
        tmp_reg    <= tmp_next;
        step_reg   <= step_next;
        halved_reg <= halved_next;
    end

    // Output word, held until taken
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_rlo_reg    <= rlo_reg;
            o_rhi_reg    <= hi_reg;
            o_step_reg   <= step_reg;
            o_first_reg  <= fh_reg;
            o_last_reg   <= lh_reg;
            o_halved_reg <= halved_reg;
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {2'b00, o_last_reg, o_first_reg, o_step_reg, o_rhi_reg, o_rlo_reg};
    assign m_axis_tuser  = o_halved_reg;

endmodule

// File: rtl/ats_checker.sv
// Port checker for axis_tick_scale, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ats_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [167:0] m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);

    logic signed [34:0] first_tick;
    logic signed [34:0] last_tick;
    logic               in_word;
    logic               out_stall;
    logic [168:0]       out_word;

    assign first_tick = m_axis_tdata[130:96];
    assign last_tick  = m_axis_tdata[165:131];
    assign in_word    = s_axis_tvalid && s_axis_tready;
    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign out_word   = {m_axis_tuser, m_axis_tdata};

    // Input closes for the word in work
    `ATS_ASSERT(a_busy_after_accept, in_word |=> !s_axis_tready, "ready high after accept")

    // Stalled output word stays
    `ATS_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(out_word), "stalled word moved")

    // Step never zero
    `ATS_ASSERT(a_step_nonzero, m_axis_tvalid |-> (m_axis_tdata[95:65] != '0), "zero tick step")

    // Ticks ordered
    `ATS_ASSERT(a_ticks_ordered, m_axis_tvalid |-> (first_tick < last_tick), "ticks out of order")

endmodule

bind axis_tick_scale ats_checker u_ats_checker (.*);

// File: verif/axis_tick_scale_tb.sv
// Self-checking testbench for axis_tick_scale: ordered range ends, tick step and end ticks.
// Drives range pairs on the slave stream and checks every result word against its own
// tick predictor. Depends only on the axis_tick_scale RTL.
module axis_tick_scale_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     RADIX         = 10;
    localparam int     MIN_INTERVALS = 5;
    localparam int     HALF_UNITS    = 2;
    localparam longint VALUE_MAX     = 64'sd2147483647;
    localparam longint VALUE_MIN     = -64'sd2147483648;
    localparam int     CHUNK_ITEMS   = 200;
    localparam int     CHUNK_COUNT   = 8;
    localparam int     PAUSE_CHUNK   = 3;
    localparam int     TAIL_ITEMS    = 150;
    localparam int     HOLD_AT       = 600;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     STALL_LIMIT   = 5000;
    localparam int     SETTLE_CYCLES = 100;

    typedef struct {
        logic signed [31:0] first_value;
        logic signed [31:0] second_value;
    } range_pair_t;

    typedef struct {
        logic signed [32:0] range_low;
        logic signed [31:0] range_high;
        logic [30:0]        tick_step;
        logic signed [34:0] first_tick;
        logic signed [34:0] last_tick;
        logic               step_halved;
    } tick_scale_t;

    logic         clk;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [167:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    range_pair_t pending_pairs[$];
    tick_scale_t expected_ticks[$];

    int  total_pushed   = 0;
    int  directed_count = 0;
    int  inputs_taken   = 0;
    int  results_seen   = 0;
    int  halved_seen    = 0;
    int  equal_seen     = 0;
    int  errors         = 0;
    int  quiet_cycles   = 0;
    int  send_idle_pct  = 0;
    int  recv_idle_pct  = 0;
    int  send_gap       = 0;
    int  recv_gap       = 0;
    int  hold_left      = 0;
    bit  hold_done      = 1'b0;
    logic in_taken      = 1'b0;
    int  idle_choice[4] = '{0, 10, 35, 70};

    axis_tick_scale dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Work out the tick layout for one pair of range ends
    function automatic tick_scale_t predict_ticks(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        tick_scale_t r;
        longint lo, hi, span, pw, quo, first, n, last, step_h, first_h, last_h;
        lo = longint'((a < b) ? a : b);
        hi = longint'((a < b) ? b : a);
        r.step_halved = 1'b0;
        if (lo == hi)
        begin
            // equal ends: widen downward by one integer unit
            r.range_low  = 33'(hi - 1);
            r.range_high = 32'(hi);
            r.tick_step  = 31'(HALF_UNITS);
            r.first_tick = 35'(HALF_UNITS * (hi - 1));
            r.last_tick  = 35'(HALF_UNITS * hi);
        end
        else
        begin
            span = hi - lo;
            pw = 1;
            while (pw * RADIX < span)
                pw = pw * RADIX;
            // floor the low end to a multiple of the step
            quo = lo / pw;
            if (quo * pw > lo)
                quo = quo - 1;
            first = quo * pw;
            n = (hi - first + pw - 1) / pw;
            if (n < 1)
                n = 1;
            last = first + n * pw;
            step_h  = HALF_UNITS * pw;
            first_h = HALF_UNITS * first;
            last_h  = HALF_UNITS * last;
            // too few intervals: halve the step, pull the ends in where they still cover
            if (n < MIN_INTERVALS)
            begin
                r.step_halved = 1'b1;
                step_h = pw;
                if (first_h + step_h <= HALF_UNITS * lo)
                    first_h = first_h + step_h;
                if (last_h - step_h >= HALF_UNITS * hi)
                    last_h = last_h - step_h;
            end
            r.range_low  = 33'(lo);
            r.range_high = 32'(hi);
            r.tick_step  = 31'(step_h);
            r.first_tick = 35'(first_h);
            r.last_tick  = 35'(last_h);
        end
        return r;
    endfunction

    // Value close to one of the extremes or to zero
    function automatic longint edge_value();
        longint v;
        case ($urandom_range(0, 2))
            0:       v = VALUE_MIN + $urandom_range(0, 20);
            1:       v = VALUE_MAX - $urandom_range(0, 20);
            default: v = longint'($urandom_range(0, 40)) - 20;
        endcase
        return v;
    endfunction

    // Mostly ranges of a chosen decade around random bases, plus noise, equal ends and extremes
    function automatic range_pair_t random_pair();
        range_pair_t pr;
        longint base, other, pw, span;
        int pick;
        pick = $urandom_range(0, 99);
        base = longint'(int'($urandom()));
        if (pick < 25)
        begin
            other = longint'(int'($urandom()));
        end
        else if (pick < 82)
        begin
            pw = 1;
            repeat ($urandom_range(0, 9))
                pw = pw * RADIX;
            if ($urandom_range(0, 2) == 0)
                base = base - base % pw;
            span = (longint'($urandom_range(1, 120)) * pw) / RADIX
                   + $urandom_range(0, 2) - 1;
            if (span < 0)
                span = 0;
            other = base + span;
            if (other > VALUE_MAX)
                other = base - span;
            if (other < VALUE_MIN)
                other = VALUE_MIN;
        end
        else if (pick < 90)
        begin
            other = base;
        end
        else
        begin
            base  = edge_value();
            other = edge_value();
        end
        if ($urandom_range(0, 1) == 1)
        begin
            pr.first_value  = 32'(other);
            pr.second_value = 32'(base);
        end
        else
        begin
            pr.first_value  = 32'(base);
            pr.second_value = 32'(other);
        end
        return pr;
    endfunction

    task automatic push_pair(input longint a, input longint b);
        range_pair_t pr;
        pr.first_value  = 32'(a);
        pr.second_value = 32'(b);
        pending_pairs.push_back(pr);
        total_pushed++;
    endtask

    task automatic wait_accepted();
        while (inputs_taken != total_pushed)
            @(negedge clk);
    endtask

    task automatic wait_drained();
        while (inputs_taken != total_pushed || expected_ticks.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Sender: hold the word until taken, then advance or idle for a burst
    always @(negedge clk)
    begin
        range_pair_t pr;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || in_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_pairs.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
            end
            else if ($urandom_range(0, 99) < send_idle_pct)
            begin
                send_gap = $urandom_range(1, 6) - 1;
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                pr = pending_pairs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {pr.second_value, pr.first_value};
            end
        end
    end

    // Receiver: one long hold-off once traffic is going, otherwise random bursts
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!hold_done && inputs_taken >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < recv_idle_pct)
        begin
            recv_gap = $urandom_range(1, 6) - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: record accepted pairs, compare result words against the oldest prediction
    always @(posedge clk)
    begin
        tick_scale_t got;
        tick_scale_t want;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_ticks.push_back(predict_ticks(s_axis_tdata[31:0],
                                                       s_axis_tdata[63:32]));
                if (s_axis_tdata[31:0] == s_axis_tdata[63:32])
                    equal_seen++;
                inputs_taken++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.range_low   = m_axis_tdata[32:0];
                got.range_high  = m_axis_tdata[64:33];
                got.tick_step   = m_axis_tdata[95:65];
                got.first_tick  = m_axis_tdata[130:96];
                got.last_tick   = m_axis_tdata[165:131];
                got.step_halved = m_axis_tuser[0];
                results_seen++;
                if (got.step_halved)
                    halved_seen++;
                if (expected_ticks.size() == 0)
                begin
                    $error("result word with no range pair outstanding");
                    errors++;
                end
                else
                begin
                    want = expected_ticks.pop_front();
                    check_field("range_low", want.range_low, got.range_low);
                    check_field("range_high", want.range_high, got.range_high);
                    check_field("tick_step", want.tick_step, got.tick_step);
                    check_field("first_tick", want.first_tick, got.first_tick);
                    check_field("last_tick", want.last_tick, got.last_tick);
                    check_field("step_halved", want.step_halved, got.step_halved);
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
            @(negedge clk);
        $display("stalled for %0d cycles with %0d results outstanding",
                 quiet_cycles, expected_ticks.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus and end of run
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, equal ends, decade boundaries, halving cases
        push_pair(VALUE_MIN, VALUE_MAX);
        push_pair(VALUE_MAX, VALUE_MIN);
        push_pair(VALUE_MIN, VALUE_MIN);
        push_pair(VALUE_MAX, VALUE_MAX);
        push_pair(0, 0);
        push_pair(5, 5);
        push_pair(0, 1);
        push_pair(1, 0);
        push_pair(-1, 0);
        push_pair(-1, 1);
        push_pair(0, 10);
        push_pair(0, 11);
        push_pair(-7, -3);
        push_pair(0, 100);
        push_pair(0, 101);
        push_pair(99, 101);
        push_pair(1000, 4000);
        push_pair(15, 25);
        push_pair(VALUE_MIN, VALUE_MIN + 1);
        push_pair(VALUE_MAX - 1, VALUE_MAX);
        push_pair(0, VALUE_MAX);
        push_pair(VALUE_MIN, 0);
        push_pair(123456789, -987654321);
        push_pair(-10, 0);
        push_pair(-1000000000, 1000000000);
        directed_count = total_pushed;
        wait_drained();

        // random chunks with changing idle rates; the sender pauses for a full drain once
        for (int chunk = 0; chunk < CHUNK_COUNT; chunk++)
        begin
            send_idle_pct = idle_choice[$urandom_range(0, 3)];
            recv_idle_pct = idle_choice[$urandom_range(0, 3)];
            for (int i = 0; i < CHUNK_ITEMS; i++)
                pending_pairs.push_back(random_pair());
            total_pushed += CHUNK_ITEMS;
            if (chunk == PAUSE_CHUNK)
                wait_drained();
            else
                wait_accepted();
        end

        // closing stretch at full rate
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < TAIL_ITEMS; i++)
            pending_pairs.push_back(random_pair());
        total_pushed += TAIL_ITEMS;
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d range pairs (%0d directed, %0d with equal ends); checked %0d results",
                 inputs_taken, directed_count, equal_seen, results_seen);
        $display("%0d results had a halved step; receiver held off once for %0d cycles",
                 halved_seen, HOLD_CYCLES);
        if (errors == 0 && expected_ticks.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ats_pkg.sv
rtl/ats_alu.sv
rtl/axis_tick_scale.sv
rtl/ats_checker.sv
verif/axis_tick_scale_tb.sv
